>>> hdl/pwfd_pkg.sv
// Shared types, codes and helper functions for the protobuf wire field decoder.
package pwfd_pkg;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [1:0] KIND_VALUE   = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_WIRE_TYPE = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;
    localparam logic [3:0] FIXED64_BYTES    = 4'd8;
    localparam logic [3:0] FIXED32_BYTES    = 4'd4;

    localparam int         APB_ADDR_W       = 3;
    localparam logic       REG_PASS_PAYLOAD = 1'b0;

    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] acc;
        logic [3:0]  count;
        logic [60:0] field;
        logic [2:0]  wtype;
        logic [63:0] remaining;
        logic        err;
    } pwfd_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [60:0] field_id;
        logic [2:0]  wire_fmt;
        logic [63:0] value;
        logic [63:0] signed_value;
        logic [1:0]  error_code;
        logic        payload_last;
        logic        message_end;
    } pwfd_result_t;

    localparam pwfd_state_t STATE_RESET = '{
        phase:     PH_TAG,
        acc:       64'd0,
        count:     4'd0,
        field:     61'd0,
        wtype:     3'd0,
        remaining: 64'd0,
        err:       1'b0
    };

    function automatic logic [5:0] varint_shift(input logic [3:0] n);
        logic [5:0] prod;
        begin
            prod = 6'({2'b00, n} * 6'd7);
            return prod;
        end
    endfunction

    function automatic logic [63:0] unzigzag(input logic [63:0] v);
        begin
            return {1'b0, v[63:1]} ^ {64{v[0]}};
        end
    endfunction

endpackage

>>> hdl/pwfd_ifs.sv
// Stream interfaces for raw message bytes and decoded field results.
interface pwfd_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwfd_field_if ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [60:0]        field_id;
    logic [2:0]         wire_fmt;
    logic [63:0]        value;
    logic signed [63:0] signed_value;
    logic [1:0]         error_code;
    logic               payload_last;
    logic               message_end;

    modport source (
        output valid, output kind, output field_id, output wire_fmt,
        output value, output signed_value, output error_code,
        output payload_last, output message_end, input ready
    );
    modport sink (
        input valid, input kind, input field_id, input wire_fmt,
        input value, input signed_value, input error_code,
        input payload_last, input message_end, output ready
    );
endinterface

>>> hdl/pwfd_apb_regs.sv
// APB configuration register block holding the payload pass-through control.
module pwfd_apb_regs
    import pwfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic                  pass_payload
);

    logic pass_payload_reg;
    logic pass_payload_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PASS_PAYLOAD);

    always_comb
    begin
        pass_payload_next = pass_payload_reg;
        if (wr_en)
        begin
            pass_payload_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_payload_reg <= 1'b1;
        end
        else
        begin
            pass_payload_reg <= pass_payload_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_PASS_PAYLOAD)
        begin
            prdata = {31'd0, pass_payload_reg};
        end
    end

    assign pass_payload = pass_payload_reg;

endmodule

>>> hdl/pwfd_core.sv
// Per-byte decode logic: next decoder state and the optional result for one byte.
module pwfd_core
    import pwfd_pkg::*;
(
    input  pwfd_state_t  state,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic         pass_payload,
    output pwfd_state_t  state_next,
    output logic         emit,
    output pwfd_result_t result
);

    logic [63:0] vacc;
    logic [63:0] facc;
    logic [3:0]  count_inc;
    logic [3:0]  fixed_need;
    logic [63:0] rem_dec;
    logic        rem_done;
    logic        in_tag;
    logic [60:0] cur_field;
    logic [2:0]  cur_type;
    logic [2:0]  tag_type;
    logic        tag_ok;

    assign vacc       = state.acc | (64'(data_byte[6:0]) << varint_shift(state.count));
    assign facc       = state.acc | (64'(data_byte) << {state.count[2:0], 3'b000});
    assign count_inc  = state.count + 4'd1;
    assign fixed_need = (state.wtype == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
    assign rem_dec    = state.remaining - 64'd1;
    assign rem_done   = (rem_dec == 64'd0);
    assign in_tag     = (state.phase == PH_TAG);
    assign cur_field  = in_tag ? 61'd0 : state.field;
    assign cur_type   = in_tag ? 3'd0 : state.wtype;
    assign tag_type   = vacc[2:0];
    assign tag_ok     = (tag_type == WT_VARINT) || (tag_type == WT_FIXED64) ||
                        (tag_type == WT_LEN) || (tag_type == WT_FIXED32);

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;

        if (state.err)
        begin
            if (last_byte)
            begin
                state_next = STATE_RESET;
            end
        end
        else
        begin
            case (state.phase)
                PH_TAG, PH_VARINT, PH_LEN:
                begin
                    if (data_byte[7])
                    begin
                        state_next.acc   = vacc;
                        state_next.count = count_inc;
                        if (count_inc >= MAX_VARINT_BYTES || last_byte)
                        begin
                            emit                = 1'b1;
                            result.kind         = KIND_ERROR;
                            result.field_id     = cur_field;
                            result.wire_fmt     = cur_type;
                            result.error_code   = (count_inc >= MAX_VARINT_BYTES) ?
                                                  ERR_TOO_LONG : ERR_TRUNCATED;
                            state_next.err      = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.acc   = 64'd0;
                        state_next.count = 4'd0;
                        if (in_tag)
                        begin
                            state_next.field = vacc[63:3];
                            state_next.wtype = tag_type;
                            if (!tag_ok || last_byte)
                            begin
                                emit                = 1'b1;
                                result.kind         = KIND_ERROR;
                                result.field_id     = vacc[63:3];
                                result.wire_fmt     = tag_type;
                                result.error_code   = tag_ok ? ERR_TRUNCATED : ERR_WIRE_TYPE;
                                state_next.err      = 1'b1;
                            end
                            else if (tag_type == WT_VARINT)
                            begin
                                state_next.phase = PH_VARINT;
                            end
                            else if (tag_type == WT_LEN)
                            begin
                                state_next.phase = PH_LEN;
                            end
                            else
                            begin
                                state_next.phase = PH_FIXED;
                            end
                        end
                        else if (state.phase == PH_VARINT)
                        begin
                            emit                = 1'b1;
                            result.kind         = KIND_VALUE;
                            result.field_id     = state.field;
                            result.wire_fmt     = state.wtype;
                            result.value        = vacc;
                            result.signed_value = unzigzag(vacc);
                            result.message_end  = last_byte;
                            state_next.phase    = PH_TAG;
                        end
                        else
                        begin
                            emit                = 1'b1;
                            result.field_id     = state.field;
                            result.wire_fmt     = state.wtype;
                            if (vacc != 64'd0 && last_byte)
                            begin
                                result.kind       = KIND_ERROR;
                                result.error_code = ERR_TRUNCATED;
                            end
                            else
                            begin
                                result.kind        = KIND_LENGTH;
                                result.value       = vacc;
                                result.message_end = last_byte;
                                if (vacc == 64'd0)
                                begin
                                    state_next.phase = PH_TAG;
                                end
                                else
                                begin
                                    state_next.remaining = vacc;
                                    state_next.phase     = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                PH_FIXED:
                begin
                    state_next.acc   = facc;
                    state_next.count = count_inc;
                    if (count_inc >= fixed_need)
                    begin
                        emit                = 1'b1;
                        result.kind         = KIND_VALUE;
                        result.field_id     = state.field;
                        result.wire_fmt     = state.wtype;
                        result.value        = facc;
                        result.message_end  = last_byte;
                        state_next.acc      = 64'd0;
                        state_next.count    = 4'd0;
                        state_next.phase    = PH_TAG;
                    end
                    else if (last_byte)
                    begin
                        emit                = 1'b1;
                        result.kind         = KIND_ERROR;
                        result.field_id     = state.field;
                        result.wire_fmt     = state.wtype;
                        result.error_code   = ERR_TRUNCATED;
                    end
                end
                PH_PAYLOAD:
                begin
                    state_next.remaining = rem_dec;
                    if (!rem_done && last_byte)
                    begin
                        emit                = 1'b1;
                        result.kind         = KIND_ERROR;
                        result.field_id     = state.field;
                        result.wire_fmt     = state.wtype;
                        result.error_code   = ERR_TRUNCATED;
                    end
                    else
                    begin
                        if (rem_done)
                        begin
                            state_next.phase = PH_TAG;
                        end
                        if (pass_payload)
                        begin
                            emit                = 1'b1;
                            result.kind         = KIND_PAYLOAD;
                            result.field_id     = state.field;
                            result.wire_fmt     = state.wtype;
                            result.value        = {56'd0, data_byte};
                            result.payload_last = rem_done;
                            result.message_end  = rem_done && last_byte;
                        end
                    end
                end
                default:
                begin
                    state_next = STATE_RESET;
                end
            endcase

            if (last_byte && state.phase <= PH_PAYLOAD)
            begin
                state_next = STATE_RESET;
            end
        end
    end

endmodule

>>> hdl/protobuf_wire_field_decoder.sv
// Top level of the protobuf wire field decoder: input stage, decode state and result register.
// A byte is held in the input register; its result, if any, goes to the result register.
// One byte per cycle unless stalled; the decode state loops through one register stage.
// Ready is high while the input or result register is free or the held byte gives no result.
// Reset clears the decoder to expect a tag, drops pending bytes and results,
// and sets pass_payload to 1.
module protobuf_wire_field_decoder
    import pwfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    pwfd_byte_if.sink             byte_stream,
    pwfd_field_if.source          field_stream
);

    logic         pass_payload;
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    pwfd_state_t  state_reg;
    pwfd_state_t  state_next;
    pwfd_state_t  core_state;
    logic         core_emit;
    pwfd_result_t core_result;
    logic         out_valid_reg;
    logic         out_valid_next;
    pwfd_result_t out_result_reg;
    logic         advance;
    logic         in_take;

    pwfd_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pass_payload (pass_payload)
    );

    pwfd_core u_core (
        .state        (state_reg),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .pass_payload (pass_payload),
        .state_next   (core_state),
        .emit         (core_emit),
        .result       (core_result)
    );

    assign advance           = in_valid_reg && (!out_valid_reg || field_stream.ready || !core_emit);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_take           = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_stream.ready)
        begin
            in_valid_next = byte_stream.valid;
        end

        state_next = state_reg;
        if (advance)
        begin
            state_next = core_state;
        end

        out_valid_next = out_valid_reg;
        if (advance && core_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (field_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_byte;
        end
        if (advance && core_emit)
        begin
            out_result_reg <= core_result;
        end
    end

    assign field_stream.valid        = out_valid_reg;
    assign field_stream.kind         = out_result_reg.kind;
    assign field_stream.field_id     = out_result_reg.field_id;
    assign field_stream.wire_fmt     = out_result_reg.wire_fmt;
    assign field_stream.value        = out_result_reg.value;
    assign field_stream.signed_value = $signed(out_result_reg.signed_value);
    assign field_stream.error_code   = out_result_reg.error_code;
    assign field_stream.payload_last = out_result_reg.payload_last;
    assign field_stream.message_end  = out_result_reg.message_end;

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg == STATE_RESET)
        else $error("Decoder state not cleared after the last byte of a message.");

    a_error_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.kind == KIND_ERROR |->
            out_result_reg.value == 64'd0 && out_result_reg.signed_value == 64'd0 &&
            out_result_reg.error_code != ERR_NONE && !out_result_reg.message_end)
        else $error("Error result carries a value or marks a clean end.");

    a_payload_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.payload_last |-> out_result_reg.kind == KIND_PAYLOAD)
        else $error("Payload-last flag set on a result that is not a payload byte.");

    a_no_result_in_error: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.err |-> !core_emit)
        else $error("Result produced while an error is pending.");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !field_stream.ready && in_valid_reg && core_emit |-> !advance)
        else $error("Input stage advanced over a held result.");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the protobuf wire field decoder, with a built-in decode predictor.
module tb;
    import pwfd_pkg::*;

    localparam int NUM_DIRECTED    = 25;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTED    = 10;

    localparam logic [2:0] WT_GROUP_START = 3'd3;
    localparam logic [2:0] WT_GROUP_END   = 3'd4;
    localparam logic [2:0] WT_RESERVED_6  = 3'd6;
    localparam logic [2:0] WT_RESERVED_7  = 3'd7;

    localparam pwfd_result_t NO_FIELD = '0;

    typedef struct {
        logic [7:0]   data;
        bit           last;
        bit           typed;
        bit           has;
        pwfd_result_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pwfd_byte_if  byte_stream_if ();
    pwfd_field_if field_stream_if ();

    protobuf_wire_field_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_stream  (byte_stream_if),
        .field_stream (field_stream_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [2:0]  dec_phase;
    logic [63:0] dec_acc;
    logic [3:0]  dec_count;
    logic [60:0] dec_field;
    logic [2:0]  dec_type;
    logic [63:0] dec_remaining;
    bit          dec_err;
    bit          cfg_pass_payload;

    pwfd_result_t  expected_fields[$];
    logic [7:0]    msg_bytes[$];
    directed_row_t directed_rows[NUM_DIRECTED];
    logic [2:0]    bad_types[4] = '{WT_GROUP_START, WT_GROUP_END, WT_RESERVED_6, WT_RESERVED_7};

    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    function void start_message();
        dec_phase = PH_TAG;
        dec_acc = '0;
        dec_count = '0;
        dec_field = '0;
        dec_type = '0;
        dec_remaining = '0;
        dec_err = 1'b0;
    endfunction

    function automatic pwfd_result_t make_result(input logic [1:0] kind,
                                                 input logic [60:0] fnum,
                                                 input logic [2:0] wt,
                                                 input logic [63:0] val,
                                                 input logic [63:0] sval,
                                                 input logic [1:0] code,
                                                 input logic plast,
                                                 input logic mend);
        return '{kind, fnum, wt, val, sval, code, plast, mend};
    endfunction

    function automatic bit raise_error(input logic [1:0] code, input logic [60:0] fnum,
                                       input logic [2:0] wt, input bit last,
                                       output pwfd_result_t res);
        res = make_result(KIND_ERROR, fnum, wt, 64'd0, 64'd0, code, 1'b0, 1'b0);
        if (last)
        begin
            start_message();
        end
        else
        begin
            dec_err = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input bit last,
                                       output pwfd_result_t res);
        bit          in_tag;
        logic [60:0] fn;
        logic [2:0]  wt;
        logic [63:0] v;
        logic [3:0]  need;
        bit          done;
        res = NO_FIELD;
        if (dec_err)
        begin
            if (last)
            begin
                start_message();
            end
            return 1'b0;
        end
        case (dec_phase)
            PH_TAG, PH_VARINT, PH_LEN:
            begin
                in_tag = (dec_phase == PH_TAG);
                fn = in_tag ? 61'd0 : dec_field;
                wt = in_tag ? 3'd0 : dec_type;
                dec_acc = dec_acc | ({57'd0, b[6:0]} << (7 * dec_count));
                if (b[7])
                begin
                    dec_count = dec_count + 4'd1;
                    if (dec_count >= MAX_VARINT_BYTES)
                    begin
                        return raise_error(ERR_TOO_LONG, fn, wt, last, res);
                    end
                    if (last)
                    begin
                        return raise_error(ERR_TRUNCATED, fn, wt, last, res);
                    end
                    return 1'b0;
                end
                v = dec_acc;
                dec_acc = '0;
                dec_count = '0;
                if (in_tag)
                begin
                    if (v[2:0] != WT_VARINT && v[2:0] != WT_FIXED64 &&
                        v[2:0] != WT_LEN && v[2:0] != WT_FIXED32)
                    begin
                        return raise_error(ERR_WIRE_TYPE, v[63:3], v[2:0], last, res);
                    end
                    dec_field = v[63:3];
                    dec_type = v[2:0];
                    if (last)
                    begin
                        return raise_error(ERR_TRUNCATED, dec_field, dec_type, last, res);
                    end
                    dec_phase = (dec_type == WT_VARINT) ? PH_VARINT :
                                (dec_type == WT_LEN) ? PH_LEN : PH_FIXED;
                    return 1'b0;
                end
                if (dec_phase == PH_VARINT)
                begin
                    res = make_result(KIND_VALUE, dec_field, dec_type, v,
                                      (v >> 1) ^ {64{v[0]}}, ERR_NONE, 1'b0, last);
                    dec_phase = PH_TAG;
                    if (last)
                    begin
                        start_message();
                    end
                    return 1'b1;
                end
                if (v != 0 && last)
                begin
                    return raise_error(ERR_TRUNCATED, fn, wt, last, res);
                end
                res = make_result(KIND_LENGTH, dec_field, dec_type, v, 64'd0, ERR_NONE,
                                  1'b0, last);
                if (v == 0)
                begin
                    dec_phase = PH_TAG;
                    if (last)
                    begin
                        start_message();
                    end
                end
                else
                begin
                    dec_remaining = v;
                    dec_phase = PH_PAYLOAD;
                end
                return 1'b1;
            end
            PH_FIXED:
            begin
                need = (dec_type == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
                dec_acc = dec_acc | ({56'd0, b} << (8 * dec_count[2:0]));
                dec_count = dec_count + 4'd1;
                if (dec_count >= need)
                begin
                    res = make_result(KIND_VALUE, dec_field, dec_type, dec_acc, 64'd0,
                                      ERR_NONE, 1'b0, last);
                    dec_acc = '0;
                    dec_count = '0;
                    dec_phase = PH_TAG;
                    if (last)
                    begin
                        start_message();
                    end
                    return 1'b1;
                end
                if (last)
                begin
                    return raise_error(ERR_TRUNCATED, dec_field, dec_type, last, res);
                end
                return 1'b0;
            end
            PH_PAYLOAD:
            begin
                dec_remaining = dec_remaining - 64'd1;
                done = (dec_remaining == 0);
                if (!done && last)
                begin
                    return raise_error(ERR_TRUNCATED, dec_field, dec_type, last, res);
                end
                if (done)
                begin
                    dec_phase = PH_TAG;
                end
                if (cfg_pass_payload)
                begin
                    res = make_result(KIND_PAYLOAD, dec_field, dec_type, {56'd0, b}, 64'd0,
                                      ERR_NONE, done, done && last);
                    if (last)
                    begin
                        start_message();
                    end
                    return 1'b1;
                end
                if (last)
                begin
                    start_message();
                end
                return 1'b0;
            end
            default:
            begin
                start_message();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void append_varint(input logic [63:0] v, input int pad);
        logic [63:0] rest;
        int          nbytes;
        logic [7:0]  cur;
        rest = v;
        nbytes = 0;
        do
        begin
            rest = rest >> 7;
            nbytes++;
        end
        while (rest != 0);
        if (pad > 10 - nbytes)
        begin
            pad = 10 - nbytes;
        end
        rest = v;
        do
        begin
            cur = {1'b0, rest[6:0]};
            rest = rest >> 7;
            cur[7] = (rest != 0) || (pad > 0);
            msg_bytes.push_back(cur);
        end
        while (rest != 0);
        for (int i = 0; i < pad; i++)
        begin
            msg_bytes.push_back((i == pad - 1) ? 8'h00 : 8'h80);
        end
    endfunction

    function automatic void build_message();
        int          pick;
        int          cut;
        logic [60:0] fnum;
        logic [2:0]  wt;
        logic [63:0] v;
        msg_bytes.delete();
        if ($urandom_range(19) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                msg_bytes.push_back(8'($urandom));
            end
            return;
        end
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(9))
                0: fnum = '0;
                1: fnum = '1;
                2: fnum = 61'({$urandom, $urandom}) >> $urandom_range(60);
                default: fnum = 61'($urandom_range(1, 20));
            endcase
            pick = $urandom_range(19);
            if (pick < 5)
            begin
                wt = WT_VARINT;
            end
            else if (pick < 9)
            begin
                wt = WT_FIXED32;
            end
            else if (pick < 12)
            begin
                wt = WT_FIXED64;
            end
            else if (pick < 18)
            begin
                wt = WT_LEN;
            end
            else
            begin
                wt = bad_types[$urandom_range(3)];
            end
            append_varint({fnum, wt}, ($urandom_range(9) == 0) ? $urandom_range(1, 9) : 0);
            case ($urandom_range(7))
                0: v = '0;
                1: v = '1;
                default: v = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            case (wt)
                WT_VARINT:
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        repeat (9)
                        begin
                            msg_bytes.push_back(8'($urandom) | 8'h80);
                        end
                        msg_bytes.push_back(8'($urandom) & 8'h7f);
                    end
                    else
                    begin
                        append_varint(v, ($urandom_range(9) == 0) ? $urandom_range(1, 9) : 0);
                    end
                end
                WT_FIXED32, WT_FIXED64:
                begin
                    repeat ((wt == WT_FIXED64) ? 8 : 4)
                    begin
                        msg_bytes.push_back(8'($urandom));
                    end
                end
                WT_LEN:
                begin
                    if ($urandom_range(19) != 0)
                    begin
                        v = 64'($urandom_range(0, 6));
                    end
                    append_varint(v, 0);
                    repeat ((v > 8) ? 8 : int'(v))
                    begin
                        msg_bytes.push_back(8'($urandom));
                    end
                end
                default:
                begin
                end
            endcase
        end
        if ($urandom_range(6) == 0)
        begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut)
            begin
                void'(msg_bytes.pop_back());
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                             input bit typed_has, input pwfd_result_t typed_want);
        pwfd_result_t predicted;
        bit           produced;
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_stream_if.valid <= 1'b1;
        byte_stream_if.data_byte <= b;
        byte_stream_if.last_byte <= last;
        @(posedge clk);
        while (!byte_stream_if.ready)
        begin
            @(posedge clk);
        end
        produced = decode_byte(b, last, predicted);
        if (typed)
        begin
            produced = typed_has;
            predicted = typed_want;
        end
        if (produced)
        begin
            expected_fields.push_back(predicted);
        end
    endtask

    task automatic wait_until_drained();
        byte_stream_if.valid <= 1'b0;
        while (expected_fields.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4)
        begin
            @(posedge clk);
        end
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
            begin
                $display("tb: mismatch on %s: expected %h, got %h", what, want, got);
            end
        end
    endtask

    task automatic program_pass_payload(input bit val);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({REG_PASS_PAYLOAD, 2'b00});
        pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        cfg_pass_payload = val;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        compare_field("pass_payload readback", {63'd0, val}, {32'd0, readback});
    endtask

    always @(posedge clk)
    begin
        pwfd_result_t got;
        pwfd_result_t want;
        if (rst_n && field_stream_if.valid && field_stream_if.ready)
        begin
            got = '{field_stream_if.kind, field_stream_if.field_id,
                    field_stream_if.wire_fmt, field_stream_if.value,
                    field_stream_if.signed_value, field_stream_if.error_code,
                    field_stream_if.payload_last, field_stream_if.message_end};
            if (expected_fields.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                begin
                    $display("tb: mismatch: result with none expected, kind %0d value %h",
                             got.kind, got.value);
                end
            end
            else
            begin
                want = expected_fields.pop_front();
                compare_field("kind", 64'(want.kind), 64'(got.kind));
                compare_field("field_id", 64'(want.field_id), 64'(got.field_id));
                compare_field("wire_fmt", 64'(want.wire_fmt), 64'(got.wire_fmt));
                compare_field("value", want.value, got.value);
                compare_field("signed_value", want.signed_value, got.signed_value);
                compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
                compare_field("payload_last", 64'(want.payload_last), 64'(got.payload_last));
                compare_field("message_end", 64'(want.message_end), 64'(got.message_end));
            end
        end
        field_stream_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int phase_idle[NUM_PHASES];
        int phase_stall[NUM_PHASES];
        bit phase_pass[NUM_PHASES];
        int sent;
        bit paused;
        phase_idle = '{0, 80, 0, 9, 0};
        phase_stall = '{0, 0, 80, 9, 0};
        phase_pass = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b0, NO_FIELD},
            '{8'h80, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'h01, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'h0d, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b1, 1'b1, '{KIND_VALUE, 61'd1, WT_FIXED32, 64'hffff_ffff,
                                         64'd0, ERR_NONE, 1'b0, 1'b0}},
            '{8'h12, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'h01, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hab, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'h1b, 1'b0, 1'b1, 1'b1, '{KIND_ERROR, 61'd3, WT_GROUP_START, 64'd0, 64'd0,
                                         ERR_WIRE_TYPE, 1'b0, 1'b0}},
            '{8'h55, 1'b1, 1'b1, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b0, 1'b0, NO_FIELD},
            '{8'hff, 1'b0, 1'b1, 1'b1, '{KIND_ERROR, 61'd0, WT_VARINT, 64'd0, 64'd0,
                                         ERR_TOO_LONG, 1'b0, 1'b0}},
            '{8'h00, 1'b1, 1'b1, 1'b0, NO_FIELD},
            '{8'h09, 1'b1, 1'b1, 1'b1, '{KIND_ERROR, 61'd1, WT_FIXED64, 64'd0, 64'd0,
                                         ERR_TRUNCATED, 1'b0, 1'b0}}
        };

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_stream_if.valid = 1'b0;
        byte_stream_if.data_byte = '0;
        byte_stream_if.last_byte = 1'b0;
        start_message();
        cfg_pass_payload = 1'b1;

        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        program_pass_payload(1'b1);
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].has, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_drained();
            program_pass_payload(phase_pass[p]);
            src_idle_pct = phase_idle[p];
            snk_stall_pct = phase_stall[p];
            sent = 0;
            paused = 1'b0;
            while (sent < ITEMS_PER_PHASE)
            begin
                build_message();
                foreach (msg_bytes[i])
                begin
                    send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, 1'b0, NO_FIELD);
                end
                sent += msg_bytes.size();
                if (p == 2 && !paused && sent >= ITEMS_PER_PHASE / 2)
                begin
                    wait_until_drained();
                    paused = 1'b1;
                end
            end
        end
        wait_until_drained();

        if (mismatch_count == 0 && expected_fields.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
